### sv/mvs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the VBR header reader and seek unit.
// No dependencies; mvs_div and the top level import this package.
package mvs_pkg;

    localparam int TABLE_LEN  = 100;
    localparam int TBL_AW     = 7;
    localparam int DIV_W      = 74;
    localparam int LEN_W      = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [31:0] TAG_XING  = 32'h5869_6E67;
    localparam logic [31:0] TAG_INFO  = 32'h496E_666F;
    localparam logic [10:0] SAMPLES_PER_FRAME = 11'd1152;
    // Largest frame count whose sample count fits 32 bits.
    localparam logic [31:0] FRAME_LIMIT = 32'd3728270;
    localparam logic [6:0]  LAST_PCT    = 7'd99;

    localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EST_SAMPLES   = 1'b1;

    localparam logic RES_SUMMARY = 1'b0;
    localparam logic RES_SEEK    = 1'b1;
    localparam logic ACT_BYTE    = 1'b0;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_COLLECT,
        PH_DONE
    } phase_t;

    typedef enum logic [3:0] {
        SK_IDLE,
        SK_PCT,
        SK_RD_LO,
        SK_RD_HI,
        SK_MUL,
        SK_SUM,
        SK_PROD_LO,
        SK_PROD_HI,
        SK_DIV,
        SK_DONE
    } sk_t;

endpackage

### sv/mvs_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for header bytes, seek queries and results.
// Depends on nothing.
interface mvs_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] seek_frame;

    modport source (output valid, action, data_byte, last_byte, seek_frame, input ready);
    modport sink   (input valid, action, data_byte, last_byte, seek_frame, output ready);
endinterface

interface mvs_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic        header_found;
    logic [31:0] total_samples;
    logic        has_table;
    logic        seek_valid;
    logic [31:0] byte_offset;

    modport source (output valid, result_kind, header_found, total_samples, has_table,
                    seek_valid, byte_offset, input ready);
    modport sink   (input valid, result_kind, header_found, total_samples, has_table,
                    seek_valid, byte_offset, output ready);
endinterface

### sv/mvs_ram.sv
`timescale 1ns / 1ps
// Generic one-write, one-read RAM with registered read data.
// No dependencies.
module mvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 100
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/mvs_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Uses mvs_pkg for default widths.
module mvs_div import mvs_pkg::*; #(
    parameter int DW = DIV_W,
    parameter int VW = LEN_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [DW-1:0] quot,
    output logic [VW-1:0] rem
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] q_reg;
    logic [VW-1:0] r_reg, d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [VW:0]   r_sh;
    logic          ge;

    assign r_sh = {r_reg, q_reg[DW-1]};
    assign ge   = r_sh >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[DW-2:0], ge};
            r_reg <= ge ? VW'(r_sh - {1'b0, d_reg}) : r_sh[VW-1:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n) go |-> !busy_reg)
        else $error("divider started while busy");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");

endmodule

### sv/mp3_vbr_header_and_seek.sv
`timescale 1ns / 1ps
// Top level of the VBR header reader and seek-offset unit.
// Depends on mvs_pkg, mvs_if, mvs_ram and mvs_div.
//
// A header byte is accepted every cycle while the seek sequencer is idle and
// the result register is free, and the byte that closes a run yields a summary.
// Seek-table bytes go into a 100-entry synchronous RAM. A seek query without
// a table forms the product with the file size and then divides by the length;
// with a table it first divides for the percentile, then does two RAM reads
// and the multiplies before the offset divide; the divides share the single
// serial divider. A query with zero song length answers at once.
module mp3_vbr_header_and_seek import mvs_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    mvs_in_if.sink               req,
    mvs_out_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    // Configuration registers.
    logic [31:0] file_size_reg, est_reg;

    // Header parser state.
    phase_t      phase_reg, phase_next;
    logic [55:0] win_reg, win_next;
    logic [6:0]  fcnt_reg, fcnt_next;
    logic [3:0]  flags_reg, flags_next;
    logic [31:0] acc_reg, acc_next;
    logic        run_reg, run_next;
    logic        found_reg, found_next;
    logic [31:0] song_reg, song_next;
    logic        tv_reg, tv_next;

    logic        hdr_take, seek_take, space;
    logic [63:0] whole;
    logic [7:0]  ts, tbl_end, cend, o_ext;
    logic        in_tbl;
    logic [31:0] acc_shift;
    logic [42:0] fc_prod;
    logic        ram_we;
    logic [TBL_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]  ram_rdata;

    // Seek sequencer.
    sk_t         sk_reg, sk_next;
    logic [31:0] tgt;
    logic [31:0] tgt_reg;
    logic        tbl_mode_reg;
    logic [6:0]  pct_reg;
    logic [31:0] within_reg;
    logic [7:0]  low_reg;
    logic [8:0]  high, step;
    logic [39:0] ma_reg;
    logic [40:0] mb_reg;
    logic [41:0] num_reg;
    logic [63:0] plo_reg;
    logic [41:0] phi;
    logic [DIV_W-1:0] prod;
    logic        div_go, div_busy, div_done;
    logic [DIV_W-1:0] div_dividend, div_q;
    logic [31:0] div_r;

    // Result register.
    logic        rsp_vld_reg;
    logic        kind_reg, hf_reg, ht_reg, sv_reg;
    logic [31:0] tot_reg, off_reg;

    assign space     = !rsp_vld_reg || rsp.ready;
    assign req.ready = (sk_reg == SK_IDLE) && space;
    assign hdr_take  = req.valid && req.ready && (req.action == ACT_BYTE);
    assign seek_take = req.valid && req.ready && (req.action != ACT_BYTE);

    // ---------------------------------------------------------------
    // Configuration: index outside the list is dropped.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_size_reg <= '0;
            est_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FILE_SIZE:   file_size_reg <= cfg_data;
                CFG_EST_SAMPLES: est_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Header parser. In COLLECT the run is always active, so the field
    // offsets below come straight from the registers.
    // ---------------------------------------------------------------
    assign whole     = {(run_reg ? win_reg : 56'd0), req.data_byte};
    assign ts        = (flags_reg[0] ? 8'd4 : 8'd0) + (flags_reg[1] ? 8'd4 : 8'd0);
    assign tbl_end   = ts + 8'(TABLE_LEN);
    assign o_ext     = {1'b0, fcnt_reg};
    assign in_tbl    = flags_reg[2] && (o_ext >= ts) && (o_ext < tbl_end);
    assign cend      = (flags_reg[2] && tbl_end >= 8'd4) ? tbl_end : 8'd4;
    assign acc_shift = {acc_reg[23:0], req.data_byte};
    assign fc_prod   = 43'(acc_shift) * 43'(SAMPLES_PER_FRAME);

    always_comb
    begin
        phase_next = phase_reg;
        win_next   = win_reg;
        fcnt_next  = fcnt_reg;
        flags_next = flags_reg;
        acc_next   = acc_reg;
        run_next   = run_reg;
        found_next = found_reg;
        song_next  = song_reg;
        tv_next    = tv_reg;
        if (hdr_take)
        begin
            if (!run_reg)
            begin
                song_next  = est_reg;
                tv_next    = 1'b0;
                found_next = 1'b0;
                win_next   = '0;
                phase_next = PH_SEARCH;
                fcnt_next  = '0;
                flags_next = '0;
                acc_next   = '0;
            end
            case (phase_next)
                PH_SEARCH:
                begin
                    win_next = whole[55:0];
                    if ((whole[63:32] == TAG_XING || whole[63:32] == TAG_INFO)
                        && whole[31:4] == 28'd0)
                    begin
                        flags_next = whole[3:0];
                        fcnt_next  = '0;
                        acc_next   = '0;
                        phase_next = PH_COLLECT;
                    end
                end
                PH_COLLECT:
                begin
                    if (flags_reg[0] && fcnt_reg < 7'd4)
                    begin
                        acc_next = acc_shift;
                    end
                    if (in_tbl && o_ext == tbl_end - 8'd1)
                    begin
                        tv_next = 1'b1;
                    end
                    if (fcnt_reg == 7'd3)
                    begin
                        found_next = 1'b1;
                        if (flags_reg[0] && acc_shift != 32'd0)
                        begin
                            song_next = (acc_shift > FRAME_LIMIT) ? 32'hFFFF_FFFF
                                                                   : fc_prod[31:0];
                        end
                    end
                    fcnt_next = fcnt_reg + 7'd1;
                    if (o_ext + 8'd1 >= cend)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                default: ;
            endcase
            run_next = !req.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            win_reg   <= '0;
            fcnt_reg  <= '0;
            flags_reg <= '0;
            acc_reg   <= '0;
            run_reg   <= 1'b0;
            found_reg <= 1'b0;
            song_reg  <= '0;
            tv_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            win_reg   <= win_next;
            fcnt_reg  <= fcnt_next;
            flags_reg <= flags_next;
            acc_reg   <= acc_next;
            run_reg   <= run_next;
            found_reg <= found_next;
            song_reg  <= song_next;
            tv_reg    <= tv_next;
        end
    end

    // Store table bytes as they arrive.
    assign ram_we    = hdr_take && run_reg && (phase_reg == PH_COLLECT) && in_tbl;
    assign ram_waddr = TBL_AW'(o_ext - ts);

    mvs_ram #(.WIDTH(8), .DEPTH(TABLE_LEN)) u_tbl (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.data_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Seek sequencer: clamp; with a table, percentile divide, two table reads
    // and forming the numerator; then multiply by file size, divide by length.
    // ---------------------------------------------------------------
    assign tgt = (req.seek_frame >= song_reg) ? song_reg - 32'd1 : req.seek_frame;

    always_comb
    begin
        sk_next = sk_reg;
        case (sk_reg)
            SK_IDLE:
            begin
                if (seek_take && song_reg != 32'd0)
                begin
                    sk_next = tv_reg ? SK_PCT : SK_PROD_LO;
                end
            end
            SK_PCT:     if (div_done) sk_next = SK_RD_LO;
            SK_RD_LO:   sk_next = SK_RD_HI;
            SK_RD_HI:   sk_next = SK_MUL;
            SK_MUL:     sk_next = SK_SUM;
            SK_SUM:     sk_next = SK_PROD_LO;
            SK_PROD_LO: sk_next = SK_PROD_HI;
            SK_PROD_HI: sk_next = SK_DIV;
            SK_DIV:     if (div_done) sk_next = SK_DONE;
            SK_DONE:    if (space) sk_next = SK_IDLE;
            default:    sk_next = SK_IDLE;
        endcase
    end

    assign phi  = 42'(file_size_reg) * 42'(num_reg[41:32]);
    assign prod = {10'd0, plo_reg} + {phi, 32'd0};
    assign high = (pct_reg == LAST_PCT) ? 9'd256 : {1'b0, ram_rdata};
    assign step = (high > {1'b0, low_reg}) ? high - {1'b0, low_reg} : 9'd0;

    always_comb
    begin
        div_go       = 1'b0;
        div_dividend = DIV_W'(39'(tgt) * 39'd100);
        ram_raddr    = pct_reg;
        case (sk_reg)
            SK_IDLE:
            begin
                div_go = seek_take && song_reg != 32'd0 && tv_reg;
            end
            SK_RD_HI:
            begin
                ram_raddr = (pct_reg == LAST_PCT) ? pct_reg : pct_reg + 7'd1;
            end
            SK_PROD_HI:
            begin
                div_go       = 1'b1;
                div_dividend = prod;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sk_reg <= SK_IDLE;
        end
        else
        begin
            sk_reg <= sk_next;
        end
    end

    // Datapath holding registers.
    always_ff @(posedge clk)
    begin
        case (sk_reg)
            SK_IDLE:
            begin
                if (seek_take)
                begin
                    tgt_reg      <= tgt;
                    num_reg      <= {10'd0, tgt};
                    tbl_mode_reg <= tv_reg;
                end
            end
            SK_PCT:
            begin
                if (div_done)
                begin
                    pct_reg    <= div_q[6:0];
                    within_reg <= div_r;
                end
            end
            SK_RD_HI:   low_reg <= ram_rdata;
            SK_MUL:
            begin
                ma_reg <= 40'(low_reg) * 40'(song_reg);
                mb_reg <= 41'(step) * 41'(within_reg);
            end
            SK_SUM:     num_reg <= 42'(ma_reg) + 42'(mb_reg);
            SK_PROD_LO: plo_reg <= 64'(file_size_reg) * 64'(num_reg[31:0]);
            default: ;
        endcase
    end

    mvs_div #(.DW(DIV_W), .VW(LEN_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_dividend),
        .divisor  (song_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    // ---------------------------------------------------------------
    // Result register: load a summary on the closing byte, a seek answer
    // at once for zero length or when the sequencer finishes.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else if ((hdr_take && req.last_byte) || (seek_take && song_reg == 32'd0)
                 || (sk_reg == SK_DONE && space))
        begin
            rsp_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_take && req.last_byte)
        begin
            kind_reg <= RES_SUMMARY;
            hf_reg   <= found_next;
            tot_reg  <= song_next;
            ht_reg   <= tv_next;
            sv_reg   <= 1'b0;
            off_reg  <= '0;
        end
        else if (seek_take && song_reg == 32'd0)
        begin
            kind_reg <= RES_SEEK;
            hf_reg   <= found_reg;
            tot_reg  <= song_reg;
            ht_reg   <= tv_reg;
            sv_reg   <= 1'b0;
            off_reg  <= '0;
        end
        else if (sk_reg == SK_DONE && space)
        begin
            kind_reg <= RES_SEEK;
            hf_reg   <= found_reg;
            tot_reg  <= song_reg;
            ht_reg   <= tv_reg;
            sv_reg   <= 1'b1;
            off_reg  <= tbl_mode_reg ? div_q[39:8] : div_q[31:0];
        end
    end

    assign rsp.valid         = rsp_vld_reg;
    assign rsp.result_kind   = kind_reg;
    assign rsp.header_found  = hf_reg;
    assign rsp.total_samples = tot_reg;
    assign rsp.has_table     = ht_reg;
    assign rsp.seek_valid    = sv_reg;
    assign rsp.byte_offset   = off_reg;

    a_table_found: assert property (@(posedge clk) disable iff (!rst_n)
        tv_reg |-> found_reg)
        else $error("table marked valid without a found tag");
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (sk_reg != SK_IDLE) |-> !req.ready)
        else $error("input taken during a seek");
    a_seek_len: assert property (@(posedge clk) disable iff (!rst_n)
        (sk_reg != SK_IDLE) |-> (song_reg != 32'd0 && $stable(song_reg)))
        else $error("length changed during a seek");
    a_tgt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sk_reg == SK_PCT) |-> (tgt_reg < song_reg))
        else $error("seek target not clamped");

endmodule
